[rtl/bad_pkg.sv]
// ---------------------------------------------------------------------------
// bad_pkg: shared types and constants of the box average downscaler
// Command codes, size limits and the controller/datapath command bundles.
// ---------------------------------------------------------------------------
package bad_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;

  localparam int unsigned CfgW = 9;   // size register width
  localparam int unsigned PosW = 8;   // col/row field width
  localparam int unsigned ChW  = 8;   // channel width

  // pixel count and channel sum widths for the default store size
  localparam int unsigned CountW = $clog2(MaxWidth * MaxHeight + 1);
  localparam int unsigned SumW   = $clog2(((1 << ChW) - 1) * MaxWidth * MaxHeight + 1);

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [1:0] RegSrcWidth  = 2'd0;
  localparam logic [1:0] RegSrcHeight = 2'd1;
  localparam logic [1:0] RegDstWidth  = 2'd2;
  localparam logic [1:0] RegDstHeight = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic start_x;    // capture query, start horizontal ratio divide
    logic start_y;    // start vertical ratio divide
    logic div_step;   // one restoring division step
    logic box_setup;  // compute box bounds from ratios
    logic clr_acc;    // clear sums and walk to box origin
    logic rd_issue;   // issue a store read at current walk address
    logic acc_en;     // accumulate registered read data
    logic walk_next;  // advance walk position
    logic avg_start;  // load dividers for the averages
    logic out_load;   // load quotients into output register
  } bad_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_last;  // current walk position is the last of the box
  } bad_sts_t;

endpackage

[rtl/bad_ram.sv]
// ---------------------------------------------------------------------------
// bad_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bad_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/bad_ctrl.sv]
// ---------------------------------------------------------------------------
// bad_ctrl: query sequencer of the box average downscaler
// Steps ratio divides, the box walk and the final averaging divides.
// ---------------------------------------------------------------------------
module bad_ctrl #(
  parameter int unsigned AvgSteps = bad_pkg::SumW  // average divide: sum width
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                query_i,    // query item accepted
  input  logic                out_busy_i, // output register still full
  input  bad_pkg::bad_sts_t   sts_i,
  output bad_pkg::bad_cmd_t   cmd_o,
  output logic                busy_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDivX  = 3'd1;
  localparam logic [2:0] StDivY  = 3'd2;
  localparam logic [2:0] StSetup = 3'd3;
  localparam logic [2:0] StWalk  = 3'd4;
  localparam logic [2:0] StDrain = 3'd5;
  localparam logic [2:0] StAvg   = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  // ratio divide: 9-bit quotient
  localparam int unsigned RatioSteps = bad_pkg::CfgW;
  localparam int unsigned CntW       = $clog2(AvgSteps + 1);

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (query_i) begin
          cmd_o.start_x = 1'b1;
          cnt_d   = CntW'(RatioSteps - 1);
          state_d = StDivX;
        end
      end
      StDivX: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StDivY;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDivY: begin
        if (cnt_q == '0 && !cmd_o.div_step) begin
          cmd_o.start_y = 1'b1;
          cnt_d = CntW'(RatioSteps);
        end
        cmd_o.div_step = (cnt_q != '0);
        if (cnt_q == CntW'(1)) begin
          state_d = StSetup;
        end
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StSetup: begin
        cmd_o.box_setup = 1'b1;
        cnt_d   = '0;
        state_d = StWalk;
      end
      StWalk: begin
        if (cnt_q == '0) begin
          cmd_o.clr_acc = 1'b1;
          cnt_d = CntW'(1);
        end else begin
          cmd_o.rd_issue  = 1'b1;
          cmd_o.acc_en    = (cnt_q == CntW'(2));
          cnt_d           = CntW'(2);
          cmd_o.walk_next = 1'b1;
          if (sts_i.walk_last) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        cmd_o.acc_en = 1'b1;
        state_d = StAvg;
        cnt_d   = CntW'(AvgSteps);
      end
      StAvg: begin
        if (cnt_q == CntW'(AvgSteps)) begin
          cmd_o.avg_start = 1'b1;
        end else begin
          cmd_o.div_step = 1'b1;
        end
        if (cnt_q == '0) begin
          state_d = StOut;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StOut: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule

[rtl/bad_dp.sv]
// ---------------------------------------------------------------------------
// bad_dp: datapath of the box average downscaler
// Size registers, frame store, bit-serial divider, box walker, sums, output.
// ---------------------------------------------------------------------------
module bad_dp #(
  parameter int unsigned MAX_WIDTH  = bad_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = bad_pkg::MaxHeight,
  parameter int unsigned SumW       = bad_pkg::SumW,
  parameter int unsigned CountW     = bad_pkg::CountW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [bad_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      load_i,
  input  logic [bad_pkg::PosW-1:0]  col_i,
  input  logic [bad_pkg::PosW-1:0]  row_i,
  input  logic [bad_pkg::ChW-1:0]   red_i,
  input  logic [bad_pkg::ChW-1:0]   green_i,
  input  logic [bad_pkg::ChW-1:0]   blue_i,
  input  bad_pkg::bad_cmd_t         cmd_i,
  output bad_pkg::bad_sts_t         sts_o,
  output logic [bad_pkg::ChW-1:0]   red_o,
  output logic [bad_pkg::ChW-1:0]   green_o,
  output logic [bad_pkg::ChW-1:0]   blue_o
);

  localparam int unsigned CW  = bad_pkg::CfgW;
  localparam int unsigned PW  = bad_pkg::PosW;
  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned AW  = XW + YW;
  localparam int unsigned SW  = SumW;    // worst-case channel sum over a box
  localparam int unsigned NW  = CountW;  // worst-case pixel count of a box
  localparam int unsigned PXW = 3 * bad_pkg::ChW;
  localparam int unsigned MW  = 18;  // pos*ratio or (pos+1)*ratio
  localparam int unsigned SizeMax = (1 << CW) - 1;

  // size registers
  logic [CW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= CW'(256);
      src_h_q <= CW'(256);
      dst_w_q <= CW'(256);
      dst_h_q <= CW'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bad_pkg::RegSrcWidth:  src_w_q <= cfg_data_i;
        bad_pkg::RegSrcHeight: src_h_q <= cfg_data_i;
        bad_pkg::RegDstWidth:  dst_w_q <= cfg_data_i;
        bad_pkg::RegDstHeight: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, clamp to the store size
  function automatic logic [CW-1:0] eff(input logic [CW-1:0] v, input logic [CW:0] mx);
    logic [CW-1:0] r;
    begin
      r = v;
      if (v == '0) r = CW'(1);
      else if ({1'b0, v} > mx) r = mx[CW-1:0];
      return r;
    end
  endfunction

  localparam logic [CW:0] MaxW = (MAX_WIDTH  > SizeMax) ? (CW+1)'(SizeMax)
                                                        : (CW+1)'(MAX_WIDTH);
  localparam logic [CW:0] MaxH = (MAX_HEIGHT > SizeMax) ? (CW+1)'(SizeMax)
                                                        : (CW+1)'(MAX_HEIGHT);

  logic [CW-1:0] sw, sh, dw, dh;
  assign sw = eff(src_w_q, MaxW);
  assign sh = eff(src_h_q, MaxH);
  assign dw = eff(dst_w_q, MaxW);
  assign dh = eff(dst_h_q, MaxH);

  // query capture
  logic [PW-1:0] qcol_q, qrow_q;

  // sums, count and store read data
  logic [NW-1:0]  n_q;
  logic [SW-1:0]  r_sum_q, g_sum_q, b_sum_q;
  logic [PXW-1:0] rd_px;

  // shared restoring divider, three lanes (ratio uses lane 0 only)
  logic [SW-1:0] quo_q  [3];
  logic [SW-1:0] rem_q  [3];
  logic [NW-1:0] dvs_q;
  logic [CW-1:0] rx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_x) begin
      qcol_q <= col_i;
      qrow_q <= row_i;
      quo_q[0] <= SW'(sw) << (SW - CW);
      rem_q[0] <= '0;
      dvs_q    <= NW'(dw);
    end else if (cmd_i.start_y) begin
      rx_q     <= quo_q[0][CW-1:0];
      quo_q[0] <= SW'(sh) << (SW - CW);
      rem_q[0] <= '0;
      dvs_q    <= NW'(dh);
    end else if (cmd_i.avg_start) begin
      quo_q[0] <= r_sum_q;
      quo_q[1] <= g_sum_q;
      quo_q[2] <= b_sum_q;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
      rem_q[2] <= '0;
      dvs_q    <= n_q;
    end else if (cmd_i.div_step) begin
      for (int k = 0; k < 3; k++) begin
        logic [SW:0] trial;
        trial = {rem_q[k], quo_q[k][SW-1]} - {{(SW+1-NW){1'b0}}, dvs_q};
        if (!trial[SW]) begin
          rem_q[k] <= trial[SW-1:0];
          quo_q[k] <= {quo_q[k][SW-2:0], 1'b1};
        end else begin
          rem_q[k] <= {rem_q[k][SW-2:0], quo_q[k][SW-1]};
          quo_q[k] <= {quo_q[k][SW-2:0], 1'b0};
        end
      end
    end
  end

  // box bounds, clamped to the last source column/row
  logic [CW-1:0] ry;
  assign ry = quo_q[0][CW-1:0];

  logic [CW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [MW-1:0] mx0, mx1, my0, my1;
  assign mx0 = MW'(qcol_q) * MW'(rx_q);
  assign mx1 = MW'(mx0) + MW'(rx_q);
  assign my0 = MW'(qrow_q) * MW'(ry);
  assign my1 = MW'(my0) + MW'(ry);

  function automatic logic [CW-1:0] clampv(input logic [MW-1:0] v, input logic [CW-1:0] s);
    logic [MW-1:0] lim;
    begin
      lim = MW'(s) - MW'(1);
      return (v > lim) ? lim[CW-1:0] : v[CW-1:0];
    end
  endfunction

  // walk position
  logic [CW-1:0] wx_q, wy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.box_setup) begin
      x0_q <= clampv(mx0, sw);
      x1_q <= clampv(mx1, sw);
      y0_q <= clampv(my0, sh);
      y1_q <= clampv(my1, sh);
    end
    if (cmd_i.clr_acc) begin
      wx_q <= x0_q;
      wy_q <= y0_q;
      n_q  <= '0;
      r_sum_q <= '0;
      g_sum_q <= '0;
      b_sum_q <= '0;
    end else begin
      if (cmd_i.walk_next) begin
        if (wx_q == x1_q) begin
          wx_q <= x0_q;
          wy_q <= wy_q + 1'b1;
        end else begin
          wx_q <= wx_q + 1'b1;
        end
      end
      if (cmd_i.acc_en) begin
        r_sum_q <= r_sum_q + SW'(rd_px[23:16]);
        g_sum_q <= g_sum_q + SW'(rd_px[15:8]);
        b_sum_q <= b_sum_q + SW'(rd_px[7:0]);
        n_q     <= n_q + 1'b1;
      end
    end
  end

  assign sts_o.walk_last = (wx_q == x1_q) && (wy_q == y1_q);

  // frame store
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  assign we    = load_i && (32'(col_i) < MAX_WIDTH) && (32'(row_i) < MAX_HEIGHT);
  assign waddr = {YW'(row_i), XW'(col_i)};
  assign raddr = {YW'(wy_q), XW'(wx_q)};

  bad_ram #(
    .Width (PXW),
    .Depth (1 << AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({red_i, green_i, blue_i}),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (raddr),
    .rdata_o (rd_px)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      red_o   <= quo_q[0][7:0];
      green_o <= quo_q[1][7:0];
      blue_o  <= quo_q[2][7:0];
    end
  end

endmodule

[rtl/box_average_image_downscale_unit.sv]
// ---------------------------------------------------------------------------
// box_average_image_downscale_unit: RGB area-average downscaler
// Loads source pixels into a frame store and answers destination queries.
// ---------------------------------------------------------------------------
//  channel | signals                                  | role
//  in      | in_valid_i/in_stall_o, cmd/col/row/rgb   | load or query item
//  out     | out_valid_o/out_stall_i, rgb out         | averaged pixel
//  cfg     | cfg_valid_i/cfg_ready_o, index/data      | size registers
//
//  A load is written into the frame store when it is accepted. For a query,
//  the ratio divides and the averaging divide run bit-serially in one shared
//  divider, and the box walk reads the frame store once per pixel; no new
//  item is taken until the query's result enters the output stage.
//  Reset sets the size registers to 256; the store is undefined until
//  written. The next item is taken while a result waits in the output stage.
// ---------------------------------------------------------------------------
module box_average_image_downscale_unit #(
  parameter int unsigned MAX_WIDTH  = bad_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = bad_pkg::MaxHeight
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [bad_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic [bad_pkg::PosW-1:0] col_i,
  input  logic [bad_pkg::PosW-1:0] row_i,
  input  logic [bad_pkg::ChW-1:0]  red_in_i,
  input  logic [bad_pkg::ChW-1:0]  green_in_i,
  input  logic [bad_pkg::ChW-1:0]  blue_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [bad_pkg::ChW-1:0]  red_out_o,
  output logic [bad_pkg::ChW-1:0]  green_out_o,
  output logic [bad_pkg::ChW-1:0]  blue_out_o
);

  // largest effective sizes and the count/sum widths they need
  localparam int unsigned SizeMax = (1 << bad_pkg::CfgW) - 1;
  localparam int unsigned EffW    = (MAX_WIDTH  < SizeMax) ? MAX_WIDTH  : SizeMax;
  localparam int unsigned EffH    = (MAX_HEIGHT < SizeMax) ? MAX_HEIGHT : SizeMax;
  localparam int unsigned CountW  = $clog2(EffW * EffH + 1);
  localparam int unsigned SumW    = $clog2(((1 << bad_pkg::ChW) - 1) * EffW * EffH + 1);

  bad_pkg::bad_cmd_t cmd;
  bad_pkg::bad_sts_t sts;
  logic busy, acc, ov_q;

  assign in_stall_o  = busy;
  assign cfg_ready_o = 1'b1;
  assign acc = in_valid_i && !in_stall_o;

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd.out_load) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end
  assign out_valid_o = ov_q;

  bad_ctrl #(
    .AvgSteps (SumW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .query_i    (acc && cmd_i == bad_pkg::CmdQuery),
    .out_busy_i (ov_q && out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  bad_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SumW       (SumW),
    .CountW     (CountW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .load_i     (acc && cmd_i == bad_pkg::CmdLoad),
    .col_i      (col_i),
    .row_i      (row_i),
    .red_i      (red_in_i),
    .green_i    (green_in_i),
    .blue_i     (blue_in_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .red_o      (red_out_o),
    .green_o    (green_out_o),
    .blue_o     (blue_out_o)
  );

  // a result is only loaded when the output stage is free
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(ov_q && out_stall_i))
    else $error("result overwrites a waiting result");

  // a waiting result holds its red and blue values
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(red_out_o) && $stable(blue_out_o))
    else $error("stalled result changed");

  // query start only from idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_x |-> !busy)
    else $error("query started while busy");

endmodule
